>>> rtl/permutation_order_crossover_defines.svh
// Assertion macros used by the top file of the order crossover block.
`ifndef PERMUTATION_ORDER_CROSSOVER_DEFINES_SVH
`define PERMUTATION_ORDER_CROSSOVER_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define POX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define POX_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pox_pkg.sv
package pox_pkg;

    localparam int ELEM_W      = 5;
    localparam int NUM_ELEM    = 32;
    localparam int SIZE_W      = 6;
    localparam int POS_W       = 5;
    localparam int START_W     = 5;
    localparam int LEN_W       = 6;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    localparam int FPE_LSB   = 0;
    localparam int SPE_LSB   = 5;
    localparam int START_LSB = 10;
    localparam int LEN_LSB   = 15;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

    typedef enum logic [0:0] {
        ACT_LOAD = 1'b0,
        ACT_RUN  = 1'b1
    } t_action;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SETUP = 6'b000010,
        ST_SEG   = 6'b000100,
        ST_FILL  = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_EMIT  = 6'b100000
    } t_state;

    typedef struct packed {
        logic load;
        logic run;
        logic setup;
        logic seg;
        logic fill;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic seg_last;
        logic fill_last;
        logic emit_last;
    } t_dp_sts;

endpackage

>>> rtl/pox_ram.sv
module pox_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pox_ctrl.sv
module pox_ctrl import pox_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  logic    i_s_action,
    input  t_dp_sts i_sts,
    output logic    o_s_tready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_s_action == ACT_RUN) begin
                        o_cmd.run = 1'b1;
                        n_state   = ST_SETUP;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = ST_SEG;
            end
            ST_SEG: begin
                o_cmd.seg = 1'b1;
                if (i_sts.seg_last) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);

endmodule

>>> rtl/pox_datapath.sv
module pox_datapath import pox_pkg::*; #(
    parameter int MAX_PERM = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [SIZE_W-1:0]      i_cfg_wdata,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_m_tready,
    output logic                   o_m_tvalid,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tlast
);

    localparam int AW = $clog2(MAX_PERM);
    localparam int SW = $clog2(MAX_PERM + 1);
    localparam int WW = (SW > LEN_W) ? SW : LEN_W;
    localparam logic [WW-1:0] MAXP = WW'(MAX_PERM);
    localparam logic [WW-1:0] ONE  = WW'(1);
    localparam logic [WW-1:0] TWO  = WW'(2);

    function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] a, logic [WW-1:0] lim);
        logic [WW-1:0] s;
        s = WW'(a) + ONE;
        return (s >= lim) ? '0 : AW'(s);
    endfunction

    logic [SIZE_W-1:0]  r_size;
    logic [WW-1:0]      size_w;
    logic [WW-1:0]      n;
    logic [AW-1:0]      r_load_pos;
    logic [AW-1:0]      load_addr;
    logic [START_W-1:0] r_start_raw;
    logic [LEN_W-1:0]   r_len_raw;
    logic [WW-1:0]      start_s;
    logic [WW-1:0]      maxlen;
    logic [WW-1:0]      len_w;
    logic [WW-1:0]      len_s;
    logic [AW-1:0]      r_addr;
    logic [AW-1:0]      next_addr;
    logic [WW-1:0]      r_cnt;
    logic [WW-1:0]      r_need;
    logic [AW-1:0]      r_src0;
    logic [AW-1:0]      r_dst1;
    logic [AW-1:0]      r_dst2;
    logic [WW-1:0]      r_fill1;
    logic [WW-1:0]      r_fill2;
    logic [NUM_ELEM-1:0] r_mark1;
    logic [NUM_ELEM-1:0] r_mark2;
    logic               r_rd_vld;
    logic               r_rd_seg;
    logic [AW-1:0]      r_rd_addr;
    logic [ELEM_W-1:0]  p1_q;
    logic [ELEM_W-1:0]  p2_q;
    logic               parent_re;
    logic               seg_wr;
    logic               take1;
    logic               take2;
    logic               c1_we;
    logic               c2_we;
    logic [AW-1:0]      c1_waddr;
    logic [AW-1:0]      c2_waddr;
    logic [ELEM_W-1:0]  c1_wdata;
    logic [ELEM_W-1:0]  c2_wdata;
    logic [ELEM_W-1:0]  c1_q;
    logic [ELEM_W-1:0]  c2_q;
    logic               emit_issue;
    logic [AW-1:0]      r_pos;
    logic [WW-1:0]      pos_w;
    logic [WW-1:0]      src_w;
    logic [WW-1:0]      offset;
    logic [POS_W-1:0]   r_out_pos;
    logic               r_out_last;
    logic               r_out_zero1;
    logic               r_out_zero2;
    logic               r_out_valid;

    always_comb begin
        size_w = WW'(r_size);
        if (size_w < TWO) begin
            n = TWO;
        end else if (size_w > MAXP) begin
            n = MAXP;
        end else begin
            n = size_w;
        end
    end

    assign load_addr = (WW'(r_load_pos) >= n) ? '0 : r_load_pos;
    assign next_addr = wrap_inc(r_addr, n);

    always_comb begin
        start_s = (WW'(r_start_raw) >= n) ? n - ONE : WW'(r_start_raw);
        maxlen  = (start_s == '0) ? n - ONE : n - start_s;
        len_w   = WW'(r_len_raw);
        if (len_w == '0) begin
            len_s = ONE;
        end else if (len_w > maxlen) begin
            len_s = maxlen;
        end else begin
            len_s = len_w;
        end
    end

    assign parent_re = i_cmd.seg | i_cmd.fill;

    pox_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_PERM)) u_first_parent (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (load_addr),
        .i_wdata (i_s_tdata[FPE_LSB +: ELEM_W]),
        .i_re    (parent_re),
        .i_raddr (r_addr),
        .o_rdata (p1_q)
    );

    pox_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_PERM)) u_second_parent (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (load_addr),
        .i_wdata (i_s_tdata[SPE_LSB +: ELEM_W]),
        .i_re    (parent_re),
        .i_raddr (r_addr),
        .o_rdata (p2_q)
    );

    // The first child fills from the second parent and the second child from the first.
    always_comb begin
        seg_wr = r_rd_vld & r_rd_seg;
        take1  = r_rd_vld & ~r_rd_seg & ~r_mark1[p2_q] & (r_fill1 < r_need);
        take2  = r_rd_vld & ~r_rd_seg & ~r_mark2[p1_q] & (r_fill2 < r_need);
        c1_we    = seg_wr | take1;
        c2_we    = seg_wr | take2;
        c1_waddr = seg_wr ? r_rd_addr : r_dst1;
        c2_waddr = seg_wr ? r_rd_addr : r_dst2;
        c1_wdata = seg_wr ? p1_q : p2_q;
        c2_wdata = seg_wr ? p2_q : p1_q;
    end

    assign emit_issue = i_cmd.emit & (~r_out_valid | i_m_tready);

    pox_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_PERM)) u_first_child (
        .i_clk   (i_clk),
        .i_we    (c1_we),
        .i_waddr (c1_waddr),
        .i_wdata (c1_wdata),
        .i_re    (emit_issue),
        .i_raddr (r_pos),
        .o_rdata (c1_q)
    );

    pox_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_PERM)) u_second_child (
        .i_clk   (i_clk),
        .i_we    (c2_we),
        .i_waddr (c2_waddr),
        .i_wdata (c2_wdata),
        .i_re    (emit_issue),
        .i_raddr (r_pos),
        .o_rdata (c2_q)
    );

    // Positions left unfilled lie just past the filled run, in cyclic order from the fill start.
    always_comb begin
        pos_w = WW'(r_pos);
        src_w = WW'(r_src0);
        if (pos_w >= src_w) begin
            offset = pos_w - src_w;
        end else begin
            offset = pos_w + n - src_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= SIZE_RESET;
            r_load_pos  <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_load_pos <= wrap_inc(load_addr, n);
            end else if (i_cmd.run) begin
                r_load_pos <= '0;
            end
            r_rd_vld <= parent_re;
            if (emit_issue) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.run) begin
            r_start_raw <= i_s_tdata[START_LSB +: START_W];
            r_len_raw   <= i_s_tdata[LEN_LSB +: LEN_W];
        end
        if (i_cmd.setup) begin
            r_addr  <= AW'(start_s);
            r_cnt   <= len_s;
            r_need  <= n - len_s;
            r_mark1 <= '0;
            r_mark2 <= '0;
            r_fill1 <= '0;
            r_fill2 <= '0;
            r_pos   <= '0;
        end
        if (parent_re) begin
            r_addr <= next_addr;
            if (i_cmd.seg && r_cnt == ONE) begin
                r_cnt  <= n;
                r_src0 <= next_addr;
                r_dst1 <= next_addr;
                r_dst2 <= next_addr;
            end else begin
                r_cnt <= r_cnt - ONE;
            end
        end
        r_rd_seg  <= i_cmd.seg;
        r_rd_addr <= r_addr;
        if (seg_wr) begin
            r_mark1[p1_q] <= 1'b1;
            r_mark2[p2_q] <= 1'b1;
        end
        if (take1) begin
            r_fill1 <= r_fill1 + ONE;
            r_dst1  <= wrap_inc(r_dst1, n);
        end
        if (take2) begin
            r_fill2 <= r_fill2 + ONE;
            r_dst2  <= wrap_inc(r_dst2, n);
        end
        if (emit_issue) begin
            r_pos       <= r_pos + AW'(1);
            r_out_pos   <= POS_W'(r_pos);
            r_out_last  <= (pos_w == n - ONE);
            r_out_zero1 <= (offset >= r_fill1) && (offset < r_need);
            r_out_zero2 <= (offset >= r_fill2) && (offset < r_need);
        end
    end

    always_comb begin
        o_sts.seg_last  = (r_cnt == ONE);
        o_sts.fill_last = (r_cnt == ONE);
        o_sts.emit_last = emit_issue & (pos_w == n - ONE);
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {1'b0,
                         r_out_zero2 ? {ELEM_W{1'b0}} : c2_q,
                         r_out_zero1 ? {ELEM_W{1'b0}} : c1_q,
                         r_out_pos};

endmodule

>>> rtl/permutation_order_crossover.sv
// Load beats are accepted back to back.
// A run beat passes through a setup step, one segment read per segment element, one fill read
// per position and a drain step; its results, one for each position of the clamped size, then
// follow at one per cycle while the receiver is ready.
// The next beat is accepted once the last result read has been issued.
// Reset is synchronous, active low: control idles, size is 32, load position 0, memories kept.
`include "permutation_order_crossover_defines.svh"

module permutation_order_crossover import pox_pkg::*; #(
    parameter int MAX_PERM = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [SIZE_W-1:0]      i_cfg_wdata,   // perm_size
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // [4:0] first_parent_elem, [9:5] second_parent_elem, [14:10] segment_start,
    // [20:15] segment_length, [23:21] zero
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_s_tuser,     // [0] action
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [4:0] position, [9:5] first_child_elem, [14:10] second_child_elem, [15] zero
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tlast      // last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    pox_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_action (i_s_tuser),
        .i_sts      (sts),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    pox_datapath #(.MAX_PERM(MAX_PERM)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_s_tdata   (i_s_tdata),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    `POX_ASSERT_NXT(a_last_beat_shown, i_clk, i_rst_n, sts.emit_last, o_m_tvalid && o_m_tlast, "final position read did not present a last beat")
    `POX_ASSERT_NXT(a_busy_after_run, i_clk, i_rst_n, cmd.run, !o_s_tready, "block accepted a beat straight after a run")
    `POX_ASSERT_IMP(a_one_phase, i_clk, i_rst_n, 1'b1, $onehot0({cmd.setup, cmd.seg, cmd.fill, cmd.emit}), "more than one datapath phase active")

endmodule

>>> sim/tb_permutation_order_crossover.sv
`timescale 1ns / 100ps

module tb_permutation_order_crossover;
    import pox_pkg::*;

    typedef logic [ELEM_W-1:0] t_elem;

    typedef struct packed {
        t_action              act;
        logic [ELEM_W-1:0]    fpe;
        logic [ELEM_W-1:0]    spe;
        logic [START_W-1:0]   start;
        logic [LEN_W-1:0]     len;
    } t_xo_beat;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [ELEM_W-1:0] kid_a;
        logic [ELEM_W-1:0] kid_b;
        logic              last;
    } t_child_pair;

    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 400;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [SIZE_W-1:0]      i_cfg_wdata = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   i_s_tuser = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;

    permutation_order_crossover uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    // Predictor state, kept in step with the beats as they are queued.
    logic [SIZE_W-1:0] size_reg;
    t_elem             par_a [NUM_ELEM];
    t_elem             par_b [NUM_ELEM];
    t_elem             kid_a [NUM_ELEM];
    t_elem             kid_b [NUM_ELEM];
    logic [31:0]       loaded;
    int                load_pos;

    t_xo_beat    beats_to_send [$];
    t_child_pair expected_children [$];
    int          queued_beats;
    int          errors;
    int          quiet_cycles;

    logic     in_beat;
    t_xo_beat cur_beat;
    int       burst_left;
    int       gap_left;
    bit       want_hold;
    bit       hold_done;
    int       hold_left;
    int       rx_mode;
    int       rx_tick;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int eff_size();
        int n;
        n = int'(size_reg);
        if (n < 2) n = 2;
        if (n > NUM_ELEM) n = NUM_ELEM;
        return n;
    endfunction

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic write_size(input int value);
        while (beats_to_send.size() != 0 || expected_children.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[SIZE_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        size_reg = value[SIZE_W-1:0];
    endtask

    task automatic queue_load(input int a, input int b);
        t_xo_beat bt;
        int n;
        int p;
        n = eff_size();
        p = load_pos;
        if (p >= n) p = 0;
        par_a[p]  = a[ELEM_W-1:0];
        par_b[p]  = b[ELEM_W-1:0];
        loaded[p] = 1'b1;
        p++;
        if (p >= n) p = 0;
        load_pos = p;
        bt       = '0;
        bt.act   = ACT_LOAD;
        bt.fpe   = a[ELEM_W-1:0];
        bt.spe   = b[ELEM_W-1:0];
        bt.start = START_W'($urandom_range(0, 31));
        bt.len   = LEN_W'($urandom_range(0, 63));
        beats_to_send.push_back(bt);
        queued_beats++;
    endtask

    // Keeps the own parent's segment in place and fills the rest cyclically
    // from the other parent, skipping elements already in the segment.
    task automatic build_child(input bit from_a, input int n, input int st, input int ln);
        t_elem       own [NUM_ELEM];
        t_elem       other [NUM_ELEM];
        t_elem       child [NUM_ELEM];
        logic [31:0] marked;
        t_elem       e;
        int          src;
        int          dst;
        int          filled;
        int          k;
        marked = '0;
        for (k = 0; k < NUM_ELEM; k++) begin
            own[k]   = from_a ? par_a[k] : par_b[k];
            other[k] = from_a ? par_b[k] : par_a[k];
            child[k] = '0;
        end
        for (k = st; k < st + ln && k < n; k++) begin
            child[k]       = own[k];
            marked[own[k]] = 1'b1;
        end
        src = st + ln;
        if (src >= n) src = 0;
        dst    = src;
        filled = 0;
        for (k = 0; k < n && filled < n - ln; k++) begin
            e = other[src];
            if (!marked[e]) begin
                child[dst] = e;
                filled++;
                dst++;
                if (dst >= n) dst = 0;
            end
            src++;
            if (src >= n) src = 0;
        end
        if (from_a) kid_a = child;
        else kid_b = child;
    endtask

    task automatic queue_run(input int start_in, input int len_in);
        t_xo_beat    bt;
        t_child_pair cp;
        logic [31:0] mask;
        int n;
        int st;
        int ln;
        int mx;
        int p;
        n    = eff_size();
        mask = (n >= 32) ? '1 : ((32'd1 << n) - 1);
        // A run must never read a parent position that was not loaded.
        while ((loaded & mask) != mask)
            queue_load($urandom_range(0, 31), $urandom_range(0, 31));
        st = start_in;
        if (st >= n) st = n - 1;
        mx = (st == 0) ? n - 1 : n - st;
        ln = len_in;
        if (ln < 1) ln = 1;
        if (ln > mx) ln = mx;
        build_child(1'b1, n, st, ln);
        build_child(1'b0, n, st, ln);
        for (p = 0; p < n; p++) begin
            cp.pos   = p[POS_W-1:0];
            cp.kid_a = kid_a[p];
            cp.kid_b = kid_b[p];
            cp.last  = (p == n - 1);
            expected_children.push_back(cp);
        end
        load_pos = 0;
        bt       = '0;
        bt.act   = ACT_RUN;
        bt.fpe   = ELEM_W'($urandom_range(0, 31));
        bt.spe   = ELEM_W'($urandom_range(0, 31));
        bt.start = start_in[START_W-1:0];
        bt.len   = len_in[LEN_W-1:0];
        beats_to_send.push_back(bt);
        queued_beats++;
    endtask

    task automatic queue_random(input int budget);
        int pool [NUM_ELEM];
        int sec [NUM_ELEM];
        int first_count;
        int n;
        int i;
        int j;
        int tmp;
        first_count = queued_beats;
        while (queued_beats - first_count < budget) begin
            n = eff_size();
            if ($urandom_range(0, 9) < 7) begin
                for (i = 0; i < NUM_ELEM; i++) pool[i] = i;
                for (i = NUM_ELEM - 1; i > 0; i--) begin
                    j       = $urandom_range(0, i);
                    tmp     = pool[i];
                    pool[i] = pool[j];
                    pool[j] = tmp;
                end
                for (i = 0; i < n; i++) sec[i] = pool[i];
                for (i = n - 1; i > 0; i--) begin
                    j      = $urandom_range(0, i);
                    tmp    = sec[i];
                    sec[i] = sec[j];
                    sec[j] = tmp;
                end
                if ($urandom_range(0, 4) == 0)
                    for (i = 0; i < n; i++) sec[i] = $urandom_range(0, 31);
                for (i = 0; i < n; i++) queue_load(pool[i], sec[i]);
                queue_run(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(0, n - 1),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(0, n));
            end else begin
                for (i = $urandom_range(1, 3); i > 0; i--)
                    queue_load($urandom_range(0, 31), $urandom_range(0, 31));
                if ($urandom_range(0, 1) == 1)
                    queue_run($urandom_range(0, 31), $urandom_range(0, 63));
            end
        end
    endtask

    initial begin
        size_reg     = SIZE_RESET;
        loaded       = '0;
        load_pos     = 0;
        queued_beats = 0;
        errors       = 0;
        want_hold    = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_size(4);
        queue_load(0, 16);
        queue_load(31, 7);
        queue_load(7, 31);
        queue_load(16, 0);
        queue_run(1, 2);
        queue_run(31, 63);
        queue_run(0, 32);
        queue_run(2, 0);
        queue_run(3, 1);
        queue_load(3, 3);
        queue_load(3, 5);
        queue_load(3, 3);
        queue_load(3, 5);
        queue_run(1, 1);
        queue_load(31, 0);
        queue_load(0, 31);
        queue_load(31, 31);
        // The load position now lies beyond the smaller size and must wrap.
        write_size(2);
        queue_load(5, 9);
        queue_run(0, 1);

        queue_random(6);
        write_size(63);
        queue_random(1);
        write_size(9);
        queue_random(6);
        write_size(0);
        queue_random(6);
        write_size(32);
        queue_random(1);
        want_hold = 1'b1;
        write_size(5);
        queue_random(12);
        write_size(1);
        queue_random(4);
        write_size(20);
        queue_random(1);

        while (beats_to_send.size() != 0 || expected_children.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    always @(negedge i_clk) begin : sender
        t_xo_beat nb;
        logic     nv;
        nb = cur_beat;
        nv = i_s_tvalid;
        if (!i_rst_n) begin
            nv         = 1'b0;
            nb         = '0;
            burst_left = 1;
            gap_left   = 0;
        end else begin
            if (in_beat) nv = 1'b0;
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (beats_to_send.size() != 0) begin
                    nb = beats_to_send.pop_front();
                    nv = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(0, 6);
                    end
                end
            end
        end
        cur_beat   = nb;
        i_s_tvalid <= nv;
        i_s_tuser  <= nb.act;
        i_s_tdata  <= {{(IN_TDATA_W - LEN_LSB - LEN_W){1'b0}}, nb.len, nb.start, nb.spe, nb.fpe};
    end

    always @(negedge i_clk) begin : receiver
        logic r;
        if (hold_left > 0) begin
            r = 1'b0;
            hold_left--;
        end else if (want_hold && !hold_done && o_m_tvalid) begin
            // Hold results back long enough for the block to stall its input.
            r         = 1'b0;
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end else begin
            if (rx_tick <= 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_tick = $urandom_range(20, 80);
            end else begin
                rx_tick--;
            end
            case (rx_mode)
                0: begin
                    r = 1'b1;
                end
                1: begin
                    r = 1'($urandom_range(0, 1));
                end
                default: begin
                    r = ($urandom_range(0, 3) == 0);
                end
            endcase
        end
        i_m_tready <= r;
    end

    always @(posedge i_clk) begin : monitor
        t_child_pair want;
        logic [POS_W-1:0]  got_pos;
        logic [ELEM_W-1:0] got_a;
        logic [ELEM_W-1:0] got_b;
        got_pos = o_m_tdata[POS_W-1:0];
        got_a   = o_m_tdata[POS_W +: ELEM_W];
        got_b   = o_m_tdata[POS_W + ELEM_W +: ELEM_W];
        in_beat <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_children.size() == 0) begin
                report($sformatf("result at position %0d with nothing expected", got_pos));
            end else begin
                want = expected_children.pop_front();
                if (got_pos !== want.pos)
                    report($sformatf("position %0d, expected %0d", got_pos, want.pos));
                if (got_a !== want.kid_a)
                    report($sformatf("first child at %0d: %0d, expected %0d",
                                     want.pos, got_a, want.kid_a));
                if (got_b !== want.kid_b)
                    report($sformatf("second child at %0d: %0d, expected %0d",
                                     want.pos, got_b, want.kid_b));
                if (o_m_tlast !== want.last)
                    report($sformatf("tlast at %0d: %0b, expected %0b",
                                     want.pos, o_m_tlast, want.last));
            end
        end
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        quiet_cycles = 0;
        hold_done    = 1'b0;
        hold_left    = 0;
        rx_mode      = 0;
        rx_tick      = 0;
        in_beat      = 1'b0;
        cur_beat     = '0;
        burst_left   = 1;
        gap_left     = 0;
    end

endmodule
